/* rtl/far_pkg.sv */
// Package: shared types and constants for the fraction add and reduce block.
package far_pkg;

  localparam int unsigned InW  = 32;
  localparam int unsigned MagW = 2 * InW + 1;

  typedef struct packed {
    logic [InW-1:0] a_numerator;
    logic [InW-1:0] a_denominator;
    logic [InW-1:0] b_numerator;
    logic [InW-1:0] b_denominator;
  } far_in_t;

  typedef struct packed {
    logic [InW-1:0] sum_numerator;
    logic [InW-1:0] sum_denominator;
    logic           overflow;
  } far_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_GCD,
    ST_GCDW,
    ST_DIVNW,
    ST_DIVD,
    ST_DIVDW,
    ST_DONE
  } far_state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic            go;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } far_div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quotient;
    logic [MagW-1:0] remainder;
  } far_div_rsp_t;

endpackage

/* rtl/fraction_add_reduce_top.sv */
// Top level: adds two fractions and reduces the sum by its Euclid GCD.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------
//   command  | in        | start_i / busy_o   | in_i  (far_in_t)
//   result   | out       | done_o strobe      | out_o (far_out_t)
//
// The three 32x32 products share the one multiplier in states MUL0, MUL1 and SUM,
// the signed sum sharing the third. Each Euclid step issues one division on the
// shared serial divider and waits for its done strobe; the two final divisions
// run the same way, then the result shows with done_o.
// The Euclid step count on the shared divider sets the worst case.
// Reset clears the sequencer; no clearing pass is needed.
// The receiver cannot stall: the result shows for one cycle with done_o.
// A transaction is accepted when start_i is high while busy_o is low.
module fraction_add_reduce_top #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  far_pkg::far_in_t  in_i,
  output logic              done_o,
  output far_pkg::far_out_t out_o
);
  import far_pkg::*;

  localparam int unsigned PW = 2 * WIDTH;

  far_state_e state_q, state_d;

  // Sign/magnitude operands of the four inputs.
  logic [WIDTH-1:0] mag_q [4];
  logic [WIDTH-1:0] mag_d [4];
  logic [3:0]       neg_q, neg_d;
  logic [PW-1:0]    p_q, p_d;           // single product register
  logic [MagW-1:0]  t_q, t_d;           // first cross product
  logic             tn_q, tn_d;
  logic [MagW-1:0]  num_q, num_d, den_q, den_d, x_q, x_d, y_q, y_d;
  logic             numn_q, numn_d, denn_q, denn_d, xn_q, xn_d, yn_q, yn_d;
  logic [MagW-1:0]  qn_q, qn_d;
  far_out_t         res_q, res_d;
  logic             done_q, done_d;

  far_div_req_t div_req;
  far_div_rsp_t div_rsp;

  logic [WIDTH-1:0] mul_a, mul_b;
  logic [PW-1:0]    prod;
  logic [WIDTH-1:0] raw [4];
  logic [MagW-1:0]  pm, sum_mag;
  logic             pn, sum_neg;
  logic [MagW-1:0]  lim;
  logic             fit_n, fit_d, qd_neg;

  far_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign raw[0] = in_i.a_numerator[WIDTH-1:0];
  assign raw[1] = in_i.a_denominator[WIDTH-1:0];
  assign raw[2] = in_i.b_numerator[WIDTH-1:0];
  assign raw[3] = in_i.b_denominator[WIDTH-1:0];

  // One shared multiplier; operands picked by the sequencer.
  assign prod = PW'(mul_a) * PW'(mul_b);
  assign pm   = MagW'(p_q);
  assign lim  = MagW'(1) << (WIDTH - 1);

  always_comb begin
    // Signed magnitude add of t and the fresh product in p.
    pn = (state_q == ST_SUM) ? ((neg_q[1] != neg_q[2]) && pm != '0) : 1'b0;
    if (tn_q == pn) begin
      sum_mag = t_q + pm;
      sum_neg = tn_q;
    end else if (t_q >= pm) begin
      sum_mag = t_q - pm;
      sum_neg = tn_q;
    end else begin
      sum_mag = pm - t_q;
      sum_neg = pn;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    fit_n  = numn_q ? (qn_q <= lim) : (qn_q < lim);
    qd_neg = (denn_q != xn_q) && div_rsp.quotient != '0;
    fit_d  = qd_neg ? (div_rsp.quotient <= lim) : (div_rsp.quotient < lim);
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    p_d     = p_q;
    t_d     = t_q;
    tn_d    = tn_q;
    num_d   = num_q;
    numn_d  = numn_q;
    den_d   = den_q;
    denn_d  = denn_q;
    x_d     = x_q;
    xn_d    = xn_q;
    y_d     = y_q;
    yn_d    = yn_q;
    qn_d    = qn_q;
    res_d   = res_q;
    done_d  = 1'b0;
    mul_a   = mag_q[0];
    mul_b   = mag_q[3];
    div_req = '{go: 1'b0, dividend: x_q, divisor: y_q};
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 4; i++) begin
            neg_d[i] = raw[i][WIDTH-1];
            mag_d[i] = raw[i][WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
          end
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        // a_n * b_d
        p_d     = prod;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        t_d     = pm;
        tn_d    = (neg_q[0] != neg_q[3]) && pm != '0;
        mul_a   = mag_q[1];
        mul_b   = mag_q[2];
        p_d     = prod;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        num_d   = sum_mag;
        numn_d  = sum_neg;
        x_d     = sum_mag;
        xn_d    = sum_neg;
        mul_a   = mag_q[1];
        mul_b   = mag_q[3];
        p_d     = prod;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        den_d   = pm;
        denn_d  = (neg_q[1] != neg_q[3]) && pm != '0;
        y_d     = pm;
        yn_d    = (neg_q[1] != neg_q[3]) && pm != '0;
        state_d = ST_GCD;
      end
      ST_GCD: begin
        if (y_q == '0) begin
          if (x_q == '0) begin
            // Zero GCD: both parts are zero, pass through.
            res_d   = '0;
            done_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            div_req = '{go: 1'b1, dividend: num_q, divisor: x_q};
            state_d = ST_DIVNW;
          end
        end else begin
          div_req = '{go: 1'b1, dividend: x_q, divisor: y_q};
          state_d = ST_GCDW;
        end
      end
      ST_GCDW: begin
        if (div_rsp.done) begin
          x_d     = y_q;
          xn_d    = yn_q;
          y_d     = div_rsp.remainder;
          yn_d    = xn_q && div_rsp.remainder != '0;
          state_d = ST_GCD;
        end
      end
      ST_DIVNW: begin
        if (div_rsp.done) begin
          qn_d    = div_rsp.quotient;
          numn_d  = (numn_q != xn_q) && div_rsp.quotient != '0;
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        div_req = '{go: 1'b1, dividend: den_q, divisor: x_q};
        state_d = ST_DIVDW;
      end
      ST_DIVDW: begin
        if (div_rsp.done) begin
          res_d.sum_numerator   = InW'($signed(numn_q ? WIDTH'(-qn_q) : WIDTH'(qn_q)));
          res_d.sum_denominator = InW'($signed(qd_neg ? WIDTH'(-div_rsp.quotient)
                                                      : WIDTH'(div_rsp.quotient)));
          res_d.overflow        = !(fit_n && fit_d);
          done_d  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    p_q    <= p_d;
    t_q    <= t_d;
    tn_q   <= tn_d;
    num_q  <= num_d;
    numn_q <= numn_d;
    den_q  <= den_d;
    denn_q <= denn_d;
    x_q    <= x_d;
    xn_q   <= xn_d;
    y_q    <= y_d;
    yn_q   <= yn_d;
    qn_q   <= qn_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = res_q;

  as_start_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_MUL0)
    else $error("accepted transaction did not start");
  as_done_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_DONE)
    else $error("result strobe outside the done state");
  as_no_go_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCDW || state_q == ST_DIVNW || state_q == ST_DIVDW) |-> !div_req.go)
    else $error("divider restarted while a division runs");

endmodule

/* rtl/far_divider.sv */
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
module far_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  far_pkg::far_div_req_t req_i,
  output far_pkg::far_div_rsp_t rsp_o
);
  import far_pkg::*;

  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [MagW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [MagW:0]   trial;
  logic [MagW:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[MagW-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.go) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(MagW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift one dividend bit in, subtract when it fits.
      if (!trial[MagW]) begin
        rem_d = trial[MagW-1:0];
        quo_d = {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_d = shifted[MagW-1:0];
        quo_d = {quo_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  as_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
  as_no_go_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  as_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

/* tb/tb_top.sv */
// Testbench for the fraction add and reduce block: directed table plus random transactions.
module tb_top;
  import far_pkg::*;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned NumRandom = 84;
  localparam int unsigned WatchdogLimit = 60000;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  far_in_t  in_i;
  logic     done_o;
  far_out_t out_o;

  fraction_add_reduce_top #(.WIDTH(WIDTH)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Signed magnitude view of a wide value, as the block's exact arithmetic.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  far_out_t sum_queue[$];
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_overflow;
  int unsigned n_zero_den;
  int unsigned idle_cycles;

  function automatic sm_t to_sm(logic [31:0] raw);
    sm_t         r;
    logic [31:0] x;
    x = raw & ((WIDTH == 32) ? 32'hFFFF_FFFF : ((32'd1 << WIDTH) - 1));
    r.neg = x[WIDTH-1];
    r.mag = r.neg ? 64'((~x + 32'd1) & ((WIDTH == 32) ? 32'hFFFF_FFFF
                                                     : ((32'd1 << WIDTH) - 1))) : 64'(x);
    if (r.neg && r.mag == 0) r.mag = 64'd1 << (WIDTH - 1);
    return r;
  endfunction

  function automatic sm_t sm_mul(sm_t a, sm_t b);
    sm_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic sm_t sm_add(sm_t a, sm_t b);
    sm_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic sm_fits(sm_t v);
    logic [63:0] lim;
    lim = 64'd1 << (WIDTH - 1);
    return v.neg ? (v.mag <= lim) : (v.mag < lim);
  endfunction

  function automatic logic [31:0] sm_pack(sm_t v);
    logic [63:0] x;
    logic [63:0] m;
    m = (64'd1 << WIDTH) - 1;
    x = (v.neg ? (64'd0 - v.mag) : v.mag) & m;
    if (x[WIDTH-1]) x = x | ~m;
    return x[31:0];
  endfunction

  // Add the two fractions and reduce by the signed Euclid GCD.
  function automatic far_out_t reduced_sum(far_in_t t);
    sm_t      num, den, x, y, r;
    far_out_t o;
    num = sm_add(sm_mul(to_sm(t.a_numerator), to_sm(t.b_denominator)),
                 sm_mul(to_sm(t.a_denominator), to_sm(t.b_numerator)));
    den = sm_mul(to_sm(t.a_denominator), to_sm(t.b_denominator));
    x = num;
    y = den;
    while (y.mag != 0) begin
      r.mag = x.mag % y.mag;
      r.neg = x.neg && (r.mag != 0);
      x = y;
      y = r;
    end
    if (x.mag != 0) begin
      num.mag = num.mag / x.mag;
      num.neg = (num.neg != x.neg) && (num.mag != 0);
      den.mag = den.mag / x.mag;
      den.neg = (den.neg != x.neg) && (den.mag != 0);
    end
    o.sum_numerator   = sm_pack(num);
    o.sum_denominator = sm_pack(den);
    o.overflow        = !(sm_fits(num) && sm_fits(den));
    return o;
  endfunction

  // Directed table; has_sum marks rows whose answer is typed in.
  typedef struct {
    far_in_t  cmd;
    logic     has_sum;
    far_out_t sum;
  } row_t;

  localparam logic [31:0] MaxP = 32'h7FFF_FFFF;
  localparam logic [31:0] MinN = 32'h8000_0000;
  localparam logic [31:0] One  = 32'd1;
  localparam logic [31:0] MOne = 32'hFFFF_FFFF;
  localparam logic [31:0] Zero = 32'd0;

  row_t dir_rows[] = '{
    // zero GCD: both parts zero pass through
    '{'{Zero, Zero, Zero, Zero}, 1'b1, '{Zero, Zero, 1'b0}},
    // zero denominator, positive numerator gives 1/0
    '{'{One, Zero, Zero, One}, 1'b1, '{One, Zero, 1'b0}},
    // 1/1 + 1/1 = 2/1
    '{'{One, One, One, One}, 1'b1, '{32'd2, One, 1'b0}},
    // 0/1 + 0/1 = 0/1
    '{'{Zero, One, Zero, One}, 1'b1, '{Zero, One, 1'b0}},
    '{'{MOne, Zero, Zero, One}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{Zero, MOne, Zero, MOne}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MaxP, One, MaxP, One}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MinN, One, MinN, One}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MinN, MinN, MinN, MinN}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MaxP, MaxP, MaxP, MaxP}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MinN, MaxP, MaxP, MinN}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{One, MOne, MOne, One}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{MaxP, MinN, One, MOne}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{32'd3, 32'd4, 32'd5, 32'd6}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{32'hFFFF_FFFD, 32'd7, 32'd2, 32'hFFFF_FFF7}, 1'b0, '{Zero, Zero, 1'b0}},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC}, 1'b0,
      '{Zero, Zero, 1'b0}},
    // Fibonacci neighbors make long Euclid chains
    '{'{32'd1836311903, 32'd1134903170, Zero, One}, 1'b0, '{Zero, Zero, 1'b0}}
  };

  // Gaps: mostly short, a few long, some none at all.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned p;
    p = $urandom_range(9);
    case (p)
      0: return MinN;
      1: return MaxP;
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      3: return 32'($urandom_range(0, 2000)) - 32'd1000;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Drop start for the gap, then hold start and payload until the block
  // takes the transaction; start stays high after acceptance while busy.
  task automatic issue(far_in_t t);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      start_i <= 1'b0;
      in_i    <= far_in_t'({$urandom, $urandom, $urandom, $urandom});
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Result side: compare each strobe against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sum_queue.size() == 0) begin
        $error("result with nothing expected: %h", out_o);
        n_errors++;
      end else begin
        far_out_t e;
        e = sum_queue.pop_front();
        n_checked++;
        if (e.overflow) n_overflow++;
        if (e.sum_denominator == 0) n_zero_den++;
        if (out_o.sum_numerator !== e.sum_numerator) begin
          $error("sum_numerator expected %h actual %h", e.sum_numerator, out_o.sum_numerator);
          n_errors++;
        end
        if (out_o.sum_denominator !== e.sum_denominator) begin
          $error("sum_denominator expected %h actual %h",
                 e.sum_denominator, out_o.sum_denominator);
          n_errors++;
        end
        if (out_o.overflow !== e.overflow) begin
          $error("overflow expected %b actual %b", e.overflow, out_o.overflow);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    far_in_t     t;
    far_out_t    model;
    int unsigned k;
    n_errors   = 0;
    n_checked  = 0;
    n_overflow = 0;
    n_zero_den = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: typed answers checked against the predictor too.
    foreach (dir_rows[i]) begin
      model = reduced_sum(dir_rows[i].cmd);
      if (dir_rows[i].has_sum && model !== dir_rows[i].sum) begin
        $error("row %0d: typed answer %h, predictor %h", i, dir_rows[i].sum, model);
        n_errors++;
      end
      sum_queue.push_back(dir_rows[i].has_sum ? dir_rows[i].sum : model);
      issue(dir_rows[i].cmd);
    end

    // Random part: mix of boundary words, small values and full-range noise.
    for (k = 0; k < NumRandom; k++) begin
      t.a_numerator   = rand_word();
      t.a_denominator = rand_word();
      t.b_numerator   = rand_word();
      t.b_denominator = rand_word();
      sum_queue.push_back(reduced_sum(t));
      issue(t);
    end
    start_i <= 1'b0;

    // Drain: wait for every result, then a margin of the worst latency.
    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (8000) @(posedge clk_i);

    $display("checked %0d sums (%0d with overflow, %0d with zero denominator)",
             n_checked, n_overflow, n_zero_den);
    $display("directed rows %0d, random transactions %0d", dir_rows.size(), NumRandom);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
